// ===== hdl/tsre_pkg.sv =====
// ----------------------------------------------------------------------------
// tsre_pkg: shared types and constants of the scatter reduce engine
// Request and result structs, opcodes, status codes, store geometry.
// ----------------------------------------------------------------------------
package tsre_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int MAX_RANK    = 4;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int RANK_CAP    = (MAX_RANK < 4) ? MAX_RANK : 4;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MAX = 3'd2;
  localparam logic [2:0] OP_MIN = 3'd3;
  localparam logic [2:0] OP_MUL = 3'd4;
  localparam logic [2:0] OP_DIV = 3'd5;

  localparam logic [2:0] REG_OP_MODE = 3'd0;
  localparam logic [2:0] REG_RANK    = 3'd1;
  localparam logic [2:0] REG_DIM0    = 3'd2;
  localparam logic [2:0] REG_DIM1    = 3'd3;
  localparam logic [2:0] REG_DIM2    = 3'd4;
  localparam logic [2:0] REG_DIM3    = 3'd5;
  localparam logic [2:0] REG_ROW_LEN = 3'd6;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [11:0]        flat_addr;
    logic signed [31:0] coord0;
    logic signed [31:0] coord1;
    logic signed [31:0] coord2;
    logic signed [31:0] coord3;
    logic [11:0]        inner_pos;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic [1:0]         status;
  } rsp_t;

  // Classified command between front and back.
  typedef struct packed {
    logic [1:0]  kind;    // request type; ERROR/IGNORE carried in status
    logic [1:0]  status;  // preset status (range, ignored) or ok
    logic        act;     // touch the store
    logic [AW-1:0] addr;
    logic [31:0] value;
  } cmd_t;

endpackage

// ===== hdl/tsre_ram.sv =====
// ----------------------------------------------------------------------------
// tsre_ram: generic single port RAM
// One read per cycle plus a write when enabled, registered read data.
// ----------------------------------------------------------------------------
module tsre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/tsre_front.sv =====
// ----------------------------------------------------------------------------
// tsre_front: request classifier and address generator
// Checks coordinates, folds them into a flat address one rank per cycle.
// ----------------------------------------------------------------------------
module tsre_front import tsre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_req,
  input  logic [2:0]  index_rank,
  input  logic [12:0] dim0_size,
  input  logic [12:0] dim1_size,
  input  logic [12:0] dim2_size,
  input  logic [12:0] dim3_size,
  input  logic [12:0] row_length,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_SCALE = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0]  state;
  req_t        req;
  logic [2:0]  step;
  logic [2:0]  rank;
  logic [25:0] row;
  logic        bad;
  logic        sticky;
  cmd_t        cmd_r;

  logic [31:0] coord;
  logic [12:0] dim;
  logic [38:0] prod;
  logic [25:0] addr_full;

  assign in_ready  = (state == S_IDLE);
  assign cmd_valid = (state == S_OUT);
  assign cmd       = cmd_r;

  always_comb begin
    unique case (step[1:0])
      2'd0: begin coord = req.coord0; dim = dim0_size; end
      2'd1: begin coord = req.coord1; dim = dim1_size; end
      2'd2: begin coord = req.coord2; dim = dim2_size; end
      default: begin coord = req.coord3; dim = dim3_size; end
    endcase
    prod = row * dim;
    addr_full = row[12:0] * row_length + 26'(req.inner_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sticky <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          req  <= in_req;
          step <= 3'd0;
          row  <= '0;
          bad  <= 1'b0;
          rank <= (index_rank == 3'd0) ? 3'd1 :
                  (index_rank > 3'(RANK_CAP)) ? 3'(RANK_CAP) : index_rank;
          cmd_r.kind  <= in_req.req_type;
          cmd_r.value <= in_req.value;
          if (in_req.req_type == REQ_LOAD || in_req.req_type == REQ_READ) begin
            cmd_r.addr   <= AW'(in_req.flat_addr);
            cmd_r.act    <= (32'(in_req.flat_addr) < 32'(STORE_DEPTH));
            cmd_r.status <= (32'(in_req.flat_addr) < 32'(STORE_DEPTH)) ? ST_OK : ST_RANGE;
            if (32'(in_req.flat_addr) >= 32'(STORE_DEPTH)) sticky <= 1'b1;
            state <= S_OUT;
          end else if (in_req.req_type == REQ_UPDATE) begin
            if (sticky) begin
              cmd_r.act <= 1'b0;
              cmd_r.status <= ST_IGNORED;
              state <= S_OUT;
            end else begin
              state <= S_WALK;
            end
          end else begin
            cmd_r.act <= 1'b0;
            cmd_r.status <= ST_OK;
            state <= S_OUT;
          end
        end
        S_WALK: begin
          if (coord[31] || coord >= 32'(dim)) begin
            bad <= 1'b1;
            state <= S_SCALE;
          end else begin
            // row stays below 4096 here, so the product fits 26 bits
            row <= (row >= 26'(STORE_DEPTH)) ? row : prod[25:0] + 26'(coord[12:0]);
            if (row >= 26'(STORE_DEPTH)) bad <= 1'b1;
            step <= step + 3'd1;
            if (step + 3'd1 == rank) state <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (bad || 13'(req.inner_pos) >= row_length || row >= 26'(STORE_DEPTH)
              || addr_full >= 26'(STORE_DEPTH)) begin
            cmd_r.act <= 1'b0;
            cmd_r.status <= ST_RANGE;
            sticky <= 1'b1;
          end else begin
            cmd_r.act <= 1'b1;
            cmd_r.status <= ST_OK;
            cmd_r.addr <= AW'(addr_full);
          end
          state <= S_OUT;
        end
        default: if (cmd_ready) state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/tsre_div.sv =====
// ----------------------------------------------------------------------------
// tsre_div: signed int32 divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tsre_div import tsre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  logic [5:0]  cnt;
  logic        busy;
  logic        neg;
  logic [31:0] den;
  logic [31:0] q;
  logic [32:0] rem;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[31]} - {1'b0, den};
  assign quotient = neg ? (~q + 32'd1) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        neg  <= dividend[31] ^ divisor[31];
        q    <= dividend[31] ? (~dividend + 32'd1) : dividend;
        den  <= divisor[31] ? (~divisor + 32'd1) : divisor;
        rem  <= '0;
      end else if (busy) begin
        if (trial[32]) begin
          rem <= {rem[31:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end else begin
          rem <= trial;
          q   <= {q[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) busy <= 1'b0;
      end
    end
  end
endmodule

// ===== hdl/tsre_back.sv =====
// ----------------------------------------------------------------------------
// tsre_back: store access and reduction unit
// Loads write, reads fetch, updates read-reduce-write; each emits a result.
// ----------------------------------------------------------------------------
module tsre_back import tsre_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd_in,
  input  logic [2:0] op_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output rsp_t       out_rsp
);
  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_RD   = 3'd1;
  localparam logic [2:0] B_OP   = 3'd2;
  localparam logic [2:0] B_MUL  = 3'd3;
  localparam logic [2:0] B_DIV  = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0]  state, state_next;
  cmd_t        c;
  rsp_t        rsp, rsp_next;
  logic        we, we_next;
  logic [31:0] wdata, wdata_next;
  logic [31:0] rdata;
  logic [31:0] a;
  logic [31:0] mul_r;
  logic [31:0] reduced;
  logic        div_start, div_start_next;
  logic        div_done;
  logic [31:0] quo;

  assign cmd_ready = (state == B_IDLE);
  assign out_valid = (state == B_OUT);
  assign out_rsp   = rsp;

  tsre_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(c.addr), .wdata(wdata), .rdata(rdata)
  );

  tsre_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(a), .divisor(c.value),
    .done(div_done), .quotient(quo)
  );

  always_comb begin
    unique case (op_mode)
      OP_ADD: reduced = rdata + c.value;
      OP_SUB: reduced = rdata - c.value;
      OP_MAX: reduced = ($signed(rdata) >= $signed(c.value)) ? rdata : c.value;
      OP_MIN: reduced = ($signed(rdata) <= $signed(c.value)) ? rdata : c.value;
      default: reduced = rdata;
    endcase
  end

  always_comb begin
    state_next     = state;
    rsp_next       = rsp;
    we_next        = 1'b0;
    wdata_next     = wdata;
    div_start_next = 1'b0;
    unique case (state)
      B_IDLE: if (cmd_valid) begin
        rsp_next.status    = cmd_in.status;
        rsp_next.read_data = '0;
        if (cmd_in.act && cmd_in.kind == REQ_LOAD) begin
          we_next    = 1'b1;
          wdata_next = cmd_in.value;
          state_next = B_OUT;
        end else if (cmd_in.act) begin
          state_next = B_RD;
        end else begin
          state_next = B_OUT;
        end
      end
      B_RD: state_next = B_OP;
      B_OP: begin
        if (c.kind == REQ_READ) begin
          rsp_next.read_data = rdata;
          state_next = B_OUT;
        end else begin
          unique case (op_mode)
            OP_MUL: state_next = B_MUL;
            OP_DIV: begin
              if (c.value == 32'd0) begin
                rsp_next.status    = ST_DIVZERO;
                rsp_next.read_data = rdata;
                state_next = B_OUT;
              end else begin
                div_start_next = 1'b1;
                state_next = B_DIV;
              end
            end
            default: begin
              we_next            = 1'b1;
              wdata_next         = reduced;
              rsp_next.read_data = reduced;
              state_next = B_OUT;
            end
          endcase
        end
      end
      B_MUL: begin
        we_next            = 1'b1;
        wdata_next         = mul_r;
        rsp_next.read_data = mul_r;
        state_next = B_OUT;
      end
      B_DIV: if (div_done) begin
        we_next            = 1'b1;
        wdata_next         = quo;
        rsp_next.read_data = quo;
        state_next = B_OUT;
      end
      B_OUT: if (out_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      we <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      we <= we_next;
      div_start <= div_start_next;
    end
  end

  always_ff @(posedge clk) begin
    wdata <= wdata_next;
    rsp   <= rsp_next;
    if (state == B_IDLE && cmd_valid) c <= cmd_in;
    if (state == B_OP) begin
      a     <= rdata;
      mul_r <= rdata * c.value;
    end
  end
endmodule

// ===== hdl/tensor_scatter_reduce_engine.sv =====
// ----------------------------------------------------------------------------
// tensor_scatter_reduce_engine: scatter reduce over an int32 tensor store
// Loads, ignored updates and undefined requests answer soonest, then reads, then
// updates, mul updates and div updates; updates take longer at higher rank, and
// range errors end sooner. Front and back each take a new request only when idle,
// with a one-entry queue between them; the slower of the two sets the request rate.
// Reset clears control, registers to reset values and the sticky error;
// the store itself is not cleared.
// ----------------------------------------------------------------------------
module tensor_scatter_reduce_engine import tsre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);
  logic [2:0]  op_mode;
  logic [2:0]  index_rank;
  logic [12:0] dim0_size, dim1_size, dim2_size, dim3_size, row_length;
  logic        f_valid, f_ready, q_valid, q_ready;
  cmd_t        f_cmd, q_cmd;
  rsp_t        b_rsp;
  logic        q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode <= 3'd0; index_rank <= 3'd1;
      dim0_size <= 13'd1; dim1_size <= 13'd1; dim2_size <= 13'd1;
      dim3_size <= 13'd1; row_length <= 13'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OP_MODE: op_mode <= cfg_wdata[2:0];
        REG_RANK:    index_rank <= cfg_wdata[2:0];
        REG_DIM0:    dim0_size <= cfg_wdata;
        REG_DIM1:    dim1_size <= cfg_wdata;
        REG_DIM2:    dim2_size <= cfg_wdata;
        REG_DIM3:    dim3_size <= cfg_wdata;
        REG_ROW_LEN: row_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tsre_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_req(in_data),
    .index_rank(index_rank), .dim0_size(dim0_size), .dim1_size(dim1_size),
    .dim2_size(dim2_size), .dim3_size(dim3_size), .row_length(row_length),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  // one-entry queue between front and back
  assign f_ready = !q_full;
  assign q_valid = q_full;
  always_ff @(posedge clk) begin
    if (rst) q_full <= 1'b0;
    else if (f_valid && f_ready) q_full <= 1'b1;
    else if (q_valid && q_ready) q_full <= 1'b0;
    if (f_valid && f_ready) q_cmd <= f_cmd;
  end

  tsre_back u_back (
    .clk(clk), .rst(rst), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_in(q_cmd),
    .op_mode(op_mode), .out_valid(out_valid), .out_ready(out_ready), .out_rsp(b_rsp)
  );

  assign out_data = b_rsp;

  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid);
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_IGNORED |-> out_data.read_data == 32'd0)
    else $error("ignored update with data");
endmodule

// ===== sim/tensor_scatter_reduce_engine_test.sv =====
// ----------------------------------------------------------------------------
// tensor_scatter_reduce_engine_test: self-checking bench of the scatter engine
// Loads, reads and reduction updates go through the request channel under
// several register settings. A scoreboard predicts each response from its own
// copy of the store, then checks each response beat in order. The sticky range
// error is provoked only in the last phase.
// ----------------------------------------------------------------------------
module tensor_scatter_reduce_engine_test;
  import tsre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 20000;

  class tensor_scoreboard;
    logic [31:0] store [STORE_DEPTH];
    bit          sticky;
    logic [2:0]  op;
    logic [2:0]  rank;
    int          dim [4];
    int          row_len;
    rsp_t        pending_q [$];
    int          fails;
    int          checked;

    function new();
      sticky  = 0;
      op      = OP_ADD;
      rank    = 3'd1;
      dim     = '{1, 1, 1, 1};
      row_len = 1;
      fails   = 0;
      checked = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        REG_OP_MODE: op = val[2:0];
        REG_RANK:    rank = val[2:0];
        REG_DIM0:    dim[0] = int'(val);
        REG_DIM1:    dim[1] = int'(val);
        REG_DIM2:    dim[2] = int'(val);
        REG_DIM3:    dim[3] = int'(val);
        REG_ROW_LEN: row_len = int'(val);
        default: ;
      endcase
    endfunction

    function int used_rank();
      int r;
      r = (rank == 0) ? 1 : int'(rank);
      if (r > RANK_CAP) r = RANK_CAP;
      return r;
    endfunction

    function int locate(req_t r);
      longint c [4];
      longint row;
      longint addr;
      c = '{r.coord0, r.coord1, r.coord2, r.coord3};
      row = 0;
      for (int j = 0; j < used_rank(); j++) begin
        if (c[j] < 0 || c[j] >= dim[j]) return -1;
        row = row * dim[j] + c[j];
      end
      if (r.inner_pos >= row_len || row >= STORE_DEPTH) return -1;
      addr = row * row_len + r.inner_pos;
      if (addr >= STORE_DEPTH) return -1;
      return int'(addr);
    endfunction

    function logic [31:0] reduce(logic [31:0] a, logic [31:0] b, inout logic [1:0] st);
      case (op)
        OP_ADD: return a + b;
        OP_SUB: return a - b;
        OP_MAX: return ($signed(a) >= $signed(b)) ? a : b;
        OP_MIN: return ($signed(a) <= $signed(b)) ? a : b;
        OP_MUL: return a * b;
        OP_DIV: begin
          if (b == 0) begin
            st = ST_DIVZERO;
            return a;
          end
          if (a == 32'h8000_0000 && b == 32'hffff_ffff) return a;
          return $signed(a) / $signed(b);
        end
        default: return a;
      endcase
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      int   addr;
      e = '0;
      e.status = ST_OK;
      case (r.req_type)
        REQ_LOAD: store[r.flat_addr] = r.value;
        REQ_READ: e.read_data = store[r.flat_addr];
        REQ_UPDATE: begin
          if (sticky) begin
            e.status = ST_IGNORED;
          end else begin
            addr = locate(r);
            if (addr < 0) begin
              e.status = ST_RANGE;
              sticky = 1;
            end else begin
              e.read_data = reduce(store[addr], r.value, e.status);
              store[addr] = e.read_data;
            end
          end
        end
        default: ;
      endcase
      pending_q.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected response data %h status %0d", $time,
                 got.read_data, got.status);
        fails++;
        return;
      end
      e = pending_q.pop_front();
      if (got.read_data !== e.read_data) begin
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, got.read_data);
        fails++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  req_t        in_data;
  logic        out_valid;
  logic        out_ready;
  rsp_t        out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [12:0] cfg_wdata;

  tensor_scoreboard sb;
  int send_idle;
  int recv_idle;
  int watch_count;
  int n_items;
  bit loaded [STORE_DEPTH];
  int loaded_q [$];

  tensor_scatter_reduce_engine i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_response(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      watch_count <= 0;
    end else begin
      watch_count <= watch_count + 1;
      if (watch_count >= WATCH_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    n_items++;
    if (r.req_type == REQ_LOAD && !loaded[r.flat_addr]) begin
      loaded[r.flat_addr] = 1;
      loaded_q.push_back(int'(r.flat_addr));
    end
    @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [12:0] val);
    in_valid <= 1'b0;
    while (sb.pending_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_all(logic [2:0] op, logic [2:0] rk, int d0, int d1, int d2, int d3,
                         int rl);
    set_reg(REG_OP_MODE, 13'(op));
    set_reg(REG_RANK, 13'(rk));
    set_reg(REG_DIM0, 13'(d0));
    set_reg(REG_DIM1, 13'(d1));
    set_reg(REG_DIM2, 13'(d2));
    set_reg(REG_DIM3, 13'(d3));
    set_reg(REG_ROW_LEN, 13'(rl));
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req(logic [1:0] kind);
    req_t r;
    r.req_type  = kind;
    r.flat_addr = 12'($urandom);
    r.coord0    = rand_word();
    r.coord1    = rand_word();
    r.coord2    = rand_word();
    r.coord3    = rand_word();
    r.inner_pos = 12'($urandom);
    r.value     = rand_word();
    return r;
  endfunction

  task automatic load(int addr, logic [31:0] v);
    req_t r;
    r = rand_req(REQ_LOAD);
    r.flat_addr = 12'(addr);
    r.value = v;
    send(r);
  endtask

  task automatic read(int addr);
    req_t r;
    r = rand_req(REQ_READ);
    r.flat_addr = 12'(addr);
    send(r);
  endtask

  task automatic update(int c0, int c1, int c2, int c3, int inner, logic [31:0] v);
    req_t r;
    r = rand_req(REQ_UPDATE);
    r.coord0 = c0;
    r.coord1 = c1;
    r.coord2 = c2;
    r.coord3 = c3;
    r.inner_pos = 12'(inner);
    r.value = v;
    send(r);
  endtask

  task automatic legal_update();
    req_t r;
    int   addr;
    r = rand_req(REQ_UPDATE);
    addr = -1;
    for (int t = 0; t < 20 && addr < 0; t++) begin
      if (sb.used_rank() > 0) r.coord0 = $urandom_range(sb.dim[0] - 1);
      if (sb.used_rank() > 1) r.coord1 = $urandom_range(sb.dim[1] - 1);
      if (sb.used_rank() > 2) r.coord2 = $urandom_range(sb.dim[2] - 1);
      if (sb.used_rank() > 3) r.coord3 = $urandom_range(sb.dim[3] - 1);
      r.inner_pos = 12'($urandom_range(sb.row_len - 1));
      addr = sb.locate(r);
    end
    if (addr < 0) begin
      r.coord0 = 0;
      r.coord1 = 0;
      r.coord2 = 0;
      r.coord3 = 0;
      r.inner_pos = 0;
      addr = sb.locate(r);
    end
    if (!loaded[addr]) load(addr, rand_word());
    send(r);
  endtask

  task automatic random_items(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 30 || loaded_q.size() == 0) load($urandom_range(STORE_DEPTH - 1), rand_word());
      else if (k < 65) legal_update();
      else if (k < 95) read(loaded_q[$urandom_range(loaded_q.size() - 1)]);
      else send(rand_req(2'd3));
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    watch_count = 0;
    n_items = 0;
    send_idle = 6;
    recv_idle = 51;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_all(OP_ADD, 3'd4, 2, 2, 2, 2, 256);
    load(0, 32'h8000_0000);
    load(4095, 32'h7fff_ffff);
    load(1, 32'd0);
    read(0);
    read(4095);
    send(rand_req(2'd3));
    update(1, 1, 1, 1, 255, 32'd1);
    set_reg(REG_OP_MODE, 13'(OP_SUB));
    update(0, 0, 0, 0, 0, 32'd1);
    set_reg(REG_OP_MODE, 13'(OP_MAX));
    update(0, 0, 0, 0, 0, 32'h7fff_ffff);
    set_reg(REG_OP_MODE, 13'(OP_MIN));
    update(0, 0, 0, 0, 0, 32'h8000_0000);
    set_reg(REG_OP_MODE, 13'(OP_MUL));
    update(1, 1, 1, 1, 255, 32'hffff_ffff);
    set_reg(REG_OP_MODE, 13'(OP_DIV));
    update(0, 0, 0, 0, 1, 32'd0);
    load(0, 32'h8000_0000);
    update(0, 0, 0, 0, 0, 32'hffff_ffff);
    update(1, 1, 1, 1, 255, 32'hffff_fff9);
    set_reg(REG_OP_MODE, 13'd6);
    update(0, 0, 0, 0, 0, 32'd5);
    set_reg(REG_OP_MODE, 13'd7);
    load(2560, 32'h1234_5678);
    update(1, 0, 1, 0, 0, 32'd5);
    read(4095);

    set_all(OP_ADD, 3'd1, 4096, 7, 9, 3, 1);
    random_items(250);
    set_all(OP_SUB, 3'd0, 64, 8191, 0, 0, 64);
    random_items(250);
    set_all(OP_MAX, 3'd2, 64, 64, 1, 1, 1);
    send_idle = 51;
    recv_idle = 6;
    random_items(250);
    set_all(OP_MIN, 3'd3, 16, 16, 16, 1, 1);
    random_items(250);
    set_all(OP_MUL, 3'd4, 8, 8, 8, 8, 1);
    random_items(250);
    set_all(OP_DIV, 3'd7, 2, 2, 2, 2, 256);
    send_idle = 0;
    recv_idle = 0;
    random_items(250);
    set_all(3'd6, 3'd1, 1, 5, 5, 5, 4096);
    random_items(200);
    set_all(3'd7, 3'd2, 4096, 1, 1, 8191, 1);
    random_items(200);

    set_all(OP_ADD, 3'd2, 8191, 0, 1, 1, 0);
    update(0, 0, 0, 0, 0, 32'd1);
    update(-1, 0, 0, 0, 0, 32'd1);
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(2) == 0) read(loaded_q[$urandom_range(loaded_q.size() - 1)]);
      else if ($urandom_range(3) == 0) load($urandom_range(STORE_DEPTH - 1), rand_word());
      else send(rand_req(REQ_UPDATE));
    end
    in_valid <= 1'b0;

    while (sb.pending_q.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Covered %0d request beats and %0d response beats over many register settings,",
             n_items, sb.checked);
    $display("all six reductions plus undefined modes, then the sticky range error.");
    if (sb.fails == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/tsre_pkg.sv
hdl/tsre_ram.sv
hdl/tsre_front.sv
hdl/tsre_div.sv
hdl/tsre_back.sv
hdl/tensor_scatter_reduce_engine.sv
sim/tensor_scatter_reduce_engine_test.sv
